>>> rtl/nbr_pkg.sv
// shared types and constants of the nack broadcast receiver
`timescale 1ns / 1ps
package nbr_pkg;

	// missing list memory geometry
	localparam int unsigned LIST_DEPTH      = 32;
	localparam int unsigned LIST_AW         = $clog2(LIST_DEPTH);
	localparam int unsigned LIST_W          = 5;
	localparam int unsigned DEF_MAX_PACKETS = 32;

	// header opcodes
	localparam logic [1:0] OP_DATA     = 2'd0;
	localparam logic [1:0] OP_DATA_ACK = 2'd1;
	localparam logic [1:0] OP_DATA_END = 2'd2;
	localparam logic [1:0] OP_RETRANS  = 2'd3;

	// result actions
	localparam logic [1:0] ACT_STORE   = 2'd0;
	localparam logic [1:0] ACT_DROP    = 2'd1;
	localparam logic [1:0] ACT_MISSING = 2'd2;
	localparam logic [1:0] ACT_ERROR   = 2'd3;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [15:0] round_number;
		logic [7:0]  packet_number;
		logic [15:0] data_end;
	} hdr_item_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [4:0]  slot;
		logic        ack_now;
		logic [5:0]  missing_total;
		logic [4:0]  missing_packet;
		logic [15:0] ack_round;
		logic [15:0] fill_end_out;
		logic        round_finished;
		logic        last;
	} res_item_t;

endpackage

>>> rtl/nbr_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
module nbr_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// read port, data holds while no read is issued
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

>>> rtl/nbr_core.sv
// receiver control: header decode, gap walk into the missing list, ack run readout
`timescale 1ns / 1ps
module nbr_core import nbr_pkg::*; #(
	parameter int unsigned MAX_PACKETS = DEF_MAX_PACKETS
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      hdr_valid,
	output logic      hdr_stall,
	input  hdr_item_t hdr,
	output logic      res_valid,
	input  logic      res_ready,
	output res_item_t res
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_WALK,
		ST_DATA,
		ST_LIST
	} state_t;

	localparam logic [7:0] MAX_PN = 8'(MAX_PACKETS);

	state_t               state_q;
	hdr_item_t            item_q;
	logic [15:0]          cur_round_q;
	logic [5:0]           expected_q;
	logic [5:0]           miss_count_q;
	logic [5:0]           retrans_q;
	logic                 closing_q;
	logic [15:0]          fill_end_q;
	logic [LIST_AW-1:0]   idx_q;

	logic                 in_range;
	logic                 same_round;
	logic                 is_retrans;
	logic                 owed;
	logic                 data_ok;
	logic                 gap;
	logic [5:0]           next_expected;
	logic                 retrans_fin;
	logic                 head_fin;
	logic                 list_last;
	logic                 fire;

	logic                 wr_en;
	logic [LIST_AW-1:0]   wr_addr;
	logic [LIST_W-1:0]    wr_data;
	logic                 rd_en;
	logic [LIST_AW-1:0]   rd_addr;
	logic [LIST_W-1:0]    rd_data;

	// header classification
	assign in_range      = item_q.packet_number < MAX_PN;
	assign same_round    = item_q.round_number == cur_round_q;
	assign is_retrans    = item_q.opcode == OP_RETRANS;
	assign owed          = retrans_q != 6'd0;
	assign data_ok       = same_round && in_range && ({2'b00, expected_q} <= item_q.packet_number);
	assign gap           = {2'b00, expected_q} < item_q.packet_number;
	assign next_expected = item_q.packet_number[5:0] + 6'd1;
	assign retrans_fin   = (retrans_q == 6'd1) && closing_q;
	assign head_fin      = (item_q.opcode == OP_DATA_END) && (miss_count_q == 6'd0);
	assign list_last     = ({1'b0, idx_q} + 6'd1) == retrans_q;
	assign fire          = res_valid && res_ready;

	assign hdr_stall = state_q != ST_IDLE;

	// result formation
	always_comb begin
		res_valid          = 1'b0;
		res.action         = ACT_STORE;
		res.slot           = '0;
		res.ack_now        = 1'b0;
		res.missing_total  = '0;
		res.missing_packet = '0;
		res.ack_round      = cur_round_q;
		res.fill_end_out   = fill_end_q;
		res.round_finished = 1'b0;
		res.last           = 1'b0;
		unique case (state_q)
			ST_EVAL: begin
				if (is_retrans) begin
					res_valid = 1'b1;
					res.last  = 1'b1;
					if (!owed) begin
						res.action = ACT_ERROR;
					end else if (same_round && in_range) begin
						res.action         = ACT_STORE;
						res.slot           = item_q.packet_number[4:0];
						res.round_finished = retrans_fin;
					end else begin
						res.action         = ACT_DROP;
						res.round_finished = retrans_fin;
					end
				end else if (owed) begin
					res_valid  = 1'b1;
					res.last   = 1'b1;
					res.action = ACT_ERROR;
				end else if (!data_ok) begin
					res_valid  = 1'b1;
					res.last   = 1'b1;
					res.action = ACT_DROP;
				end
			end
			ST_DATA: begin
				res_valid        = 1'b1;
				res.action       = ACT_STORE;
				res.slot         = item_q.packet_number[4:0];
				res.fill_end_out = item_q.data_end;
				if (item_q.opcode == OP_DATA) begin
					res.last = 1'b1;
				end else begin
					res.ack_now        = 1'b1;
					res.missing_total  = miss_count_q;
					res.round_finished = head_fin;
					res.last           = miss_count_q == 6'd0;
				end
			end
			ST_LIST: begin
				res_valid          = 1'b1;
				res.action         = ACT_MISSING;
				res.ack_now        = 1'b1;
				res.missing_total  = retrans_q;
				res.missing_packet = rd_data;
				res.last           = list_last;
			end
			default: begin
			end
		endcase
	end

	// missing list accesses: append during the gap walk, read ahead during the ack run
	assign wr_en   = (state_q == ST_WALK) && gap && !miss_count_q[5];
	assign wr_addr = miss_count_q[LIST_AW-1:0];
	assign wr_data = expected_q[LIST_W-1:0];
	assign rd_en   = fire && (((state_q == ST_DATA) && (item_q.opcode != OP_DATA)
		&& (miss_count_q != 6'd0)) || ((state_q == ST_LIST) && !list_last));
	assign rd_addr = (state_q == ST_LIST) ? idx_q + LIST_AW'(1) : '0;

	nbr_ram #(
		.WIDTH(LIST_W),
		.DEPTH(LIST_DEPTH)
	) u_list (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// sequencer and receiver state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			item_q       <= '0;
			cur_round_q  <= '0;
			expected_q   <= '0;
			miss_count_q <= '0;
			retrans_q    <= '0;
			closing_q    <= 1'b0;
			fill_end_q   <= '0;
			idx_q        <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (hdr_valid) begin
						item_q  <= hdr;
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					if (is_retrans) begin
						if (fire) begin
							if (owed) begin
								retrans_q <= retrans_q - 6'd1;
								if (retrans_fin) begin
									cur_round_q  <= cur_round_q + 16'd1;
									expected_q   <= '0;
									miss_count_q <= '0;
									closing_q    <= 1'b0;
								end
							end
							state_q <= ST_IDLE;
						end
					end else if (owed || !data_ok) begin
						if (fire) begin
							state_q <= ST_IDLE;
						end
					end else begin
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					if (gap) begin
						if (!miss_count_q[5]) begin
							miss_count_q <= miss_count_q + 6'd1;
						end
						expected_q <= expected_q + 6'd1;
					end else begin
						state_q <= ST_DATA;
					end
				end
				ST_DATA: begin
					if (fire) begin
						fill_end_q <= item_q.data_end;
						if (item_q.opcode == OP_DATA) begin
							expected_q <= next_expected;
							state_q    <= ST_IDLE;
						end else begin
							retrans_q    <= miss_count_q;
							miss_count_q <= '0;
							// end of transmission with nothing missing closes the round
							if (head_fin) begin
								cur_round_q <= cur_round_q + 16'd1;
								expected_q  <= '0;
								closing_q   <= 1'b0;
							end else begin
								expected_q <= next_expected;
								if (item_q.opcode == OP_DATA_END) begin
									closing_q <= 1'b1;
								end
							end
							if (miss_count_q == 6'd0) begin
								state_q <= ST_IDLE;
							end else begin
								idx_q   <= '0;
								state_q <= ST_LIST;
							end
						end
					end
				end
				ST_LIST: begin
					if (fire) begin
						if (list_last) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q <= idx_q + LIST_AW'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

>>> rtl/nack_broadcast_receiver_unit.sv
// top level of the nack broadcast receiver with its result output register
//
//  channel  direction  payload     handshake
//  hdr      in         hdr_item_t  hdr_valid / hdr_stall
//  res      out        res_item_t  res_valid / res_stall
//
// a header is taken while the core is idle and classified in the next cycle,
// where a drop, error or retransmission gives its one result, so such a header
// holds the input until that result is taken. a data header walks the skipped
// numbers one per cycle through the missing list write port, then gives its
// result, and an ack follows with one missing entry per cycle read from the
// list memory while the output is not stalled.
// results leave through one output register, in the cycle after the core.
// reset clears all receiver state; the missing list needs no clearing.
// a stalled result holds the core, which takes the next header once idle.
`timescale 1ns / 1ps
module nack_broadcast_receiver_unit import nbr_pkg::*; #(
	parameter int unsigned MAX_PACKETS = DEF_MAX_PACKETS
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      hdr_valid,
	output logic      hdr_stall,
	input  hdr_item_t hdr,
	output logic      res_valid,
	input  logic      res_stall,
	output res_item_t res
);

	logic      core_valid;
	logic      core_ready;
	res_item_t core_res;
	logic      out_valid_q;
	res_item_t out_q;

	assign core_ready = !out_valid_q || !res_stall;

	nbr_core #(
		.MAX_PACKETS(MAX_PACKETS)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.hdr_valid(hdr_valid),
		.hdr_stall(hdr_stall),
		.hdr      (hdr),
		.res_valid(core_valid),
		.res_ready(core_ready),
		.res      (core_res)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (core_ready) begin
			out_valid_q <= core_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (core_ready && core_valid) begin
			out_q <= core_res;
		end
	end

	assign res_valid = out_valid_q;
	assign res       = out_q;

endmodule

>>> tb/tb.sv
// self-checking testbench of the nack broadcast receiver unit
`timescale 1ns / 1ps
module tb import nbr_pkg::*;;

	localparam int PKT_LIMIT    = DEF_MAX_PACKETS;
	localparam int RANDOM_ITEMS = 400;
	localparam int LONG_HOLD    = 300;
	localparam int STALL_LIMIT  = 20000;
	localparam int DRAIN_CYCLES = 100;
	localparam int REPORT_MAX   = 10;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      hdr_valid;
	logic      hdr_stall;
	hdr_item_t hdr;
	logic      res_valid;
	logic      res_stall;
	res_item_t res;

	// idle rates and the long receiver hold request
	int tx_idle_pct = 12;
	int rx_idle_pct = 46;
	bit long_hold_req = 1'b0;

	int error_count = 0;
	int quiet_cycles = 0;

	// receiver state as predicted
	logic [15:0] cur_round;
	logic [5:0]  next_pkt;
	logic [4:0]  gap_list [LIST_DEPTH];
	logic [5:0]  gap_count;
	logic [5:0]  owed_retrans;
	logic        closing;
	logic [15:0] fill_latched;

	res_item_t step_results[$];
	res_item_t expected_results[$];

	typedef struct {
		hdr_item_t hdr;
		bit        typed;
		res_item_t want;
	} dir_row_t;

	dir_row_t directed_rows[$];

	nack_broadcast_receiver_unit #(
		.MAX_PACKETS(PKT_LIMIT)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.hdr_valid(hdr_valid),
		.hdr_stall(hdr_stall),
		.hdr(hdr),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res)
	);

	// clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic string res_text(res_item_t r);
		return $sformatf("act=%0d slot=%0d ack=%0d tot=%0d miss=%0d %s",
			r.action, r.slot, r.ack_now, r.missing_total, r.missing_packet,
			$sformatf("rnd=%0h fill=%0h fin=%0d last=%0d",
			r.ack_round, r.fill_end_out, r.round_finished, r.last));
	endfunction

	function automatic bit res_matches(res_item_t want, res_item_t got);
		return want.action === got.action && want.slot === got.slot &&
			want.ack_now === got.ack_now && want.missing_total === got.missing_total &&
			want.missing_packet === got.missing_packet && want.ack_round === got.ack_round &&
			want.fill_end_out === got.fill_end_out &&
			want.round_finished === got.round_finished && want.last === got.last;
	endfunction

	task automatic flag_error(input string msg);
		error_count++;
		if (error_count <= REPORT_MAX) begin
			$display("%0t: %s", $time, msg);
		end
	endtask

	function automatic res_item_t single_result(logic [1:0] action, logic [4:0] slot,
		logic [15:0] rnd, logic [15:0] fill);
		res_item_t r;
		r = '0;
		r.action = action;
		r.slot = slot;
		r.ack_round = rnd;
		r.fill_end_out = fill;
		r.last = 1'b1;
		return r;
	endfunction

	function automatic void start_next_round();
		cur_round = cur_round + 16'd1;
		next_pkt = '0;
		gap_count = '0;
		closing = 1'b0;
	endfunction

	// expected results of one header, state updated on the way
	function automatic void predict_header(hdr_item_t h);
		res_item_t r;
		res_item_t m;
		logic [15:0] rnd_now;
		logic [5:0] n;
		logic fin;
		step_results.delete();
		rnd_now = cur_round;
		r = '0;
		r.ack_round = rnd_now;
		r.last = 1'b1;

		// retransmission: error when nothing is owed, else counted
		if (h.opcode == OP_RETRANS) begin
			if (owed_retrans == 0) begin
				r.action = ACT_ERROR;
			end else begin
				owed_retrans = owed_retrans - 6'd1;
				if (h.round_number == rnd_now && h.packet_number < PKT_LIMIT) begin
					r.action = ACT_STORE;
					r.slot = h.packet_number[4:0];
				end else begin
					r.action = ACT_DROP;
				end
				if (owed_retrans == 0 && closing) begin
					start_next_round();
					r.round_finished = 1'b1;
				end
			end
			r.fill_end_out = fill_latched;
			step_results.push_back(r);
			return;
		end

		// data while retransmissions are owed
		if (owed_retrans != 0) begin
			r.action = ACT_ERROR;
			r.fill_end_out = fill_latched;
			step_results.push_back(r);
			return;
		end

		// foreign round, out of range or old number
		if (h.round_number != rnd_now || h.packet_number >= PKT_LIMIT ||
			h.packet_number < next_pkt) begin
			r.action = ACT_DROP;
			r.fill_end_out = fill_latched;
			step_results.push_back(r);
			return;
		end

		// record skipped numbers while the list has room
		while (next_pkt < h.packet_number) begin
			if (gap_count < LIST_DEPTH) begin
				gap_list[gap_count[4:0]] = next_pkt[4:0];
				gap_count = gap_count + 6'd1;
			end
			next_pkt = next_pkt + 6'd1;
		end
		next_pkt = 6'(h.packet_number + 8'd1);
		fill_latched = h.data_end;
		r.action = ACT_STORE;
		r.slot = h.packet_number[4:0];
		r.fill_end_out = fill_latched;
		if (h.opcode == OP_DATA) begin
			step_results.push_back(r);
			return;
		end

		// acknowledgement with its run of missing entries
		n = gap_count;
		owed_retrans = n;
		fin = 1'b0;
		if (h.opcode == OP_DATA_END) begin
			closing = 1'b1;
			fin = (n == 0);
		end
		r.ack_now = 1'b1;
		r.missing_total = n;
		r.round_finished = (n == 0) ? fin : 1'b0;
		r.last = (n == 0);
		step_results.push_back(r);
		for (int k = 0; k < int'(n); k++) begin
			m = '0;
			m.action = ACT_MISSING;
			m.ack_now = 1'b1;
			m.missing_total = n;
			m.missing_packet = gap_list[k];
			m.ack_round = rnd_now;
			m.fill_end_out = fill_latched;
			m.last = (k == int'(n) - 1);
			step_results.push_back(m);
		end
		gap_count = '0;
		if (fin) begin
			start_next_round();
		end
	endfunction

	// next random header, mostly well formed for the current state
	function automatic hdr_item_t pick_header();
		hdr_item_t h;
		int sel;
		int room;
		int span;
		int pn;
		h.opcode = OP_DATA;
		h.round_number = cur_round;
		h.packet_number = '0;
		h.data_end = 16'($urandom_range(0, 32768));
		sel = $urandom_range(0, 99);
		room = PKT_LIMIT - 1 - int'(next_pkt);

		// owed retransmissions, with some noise
		if (owed_retrans != 0) begin
			if (sel < 85) begin
				h.opcode = OP_RETRANS;
				h.packet_number = 8'($urandom_range(0, PKT_LIMIT - 1));
				if (sel < 6) begin
					h.round_number = 16'($urandom);
				end else if (sel < 10) begin
					h.packet_number = 8'($urandom_range(PKT_LIMIT, 255));
				end
			end else begin
				h.opcode = 2'($urandom_range(0, 2));
				h.packet_number = 8'($urandom_range(0, 255));
			end
			return h;
		end

		// well formed data continuing the round
		if (sel < 82 && room >= 0) begin
			if (sel < 4) begin
				span = room;
			end else if (sel < 12) begin
				span = $urandom_range(0, room);
			end else begin
				span = $urandom_range(0, (room < 3) ? room : 3);
			end
			pn = int'(next_pkt) + span;
			h.packet_number = 8'(pn);
			sel = $urandom_range(0, 99);
			if (pn == PKT_LIMIT - 1 || sel >= 80) begin
				h.opcode = OP_DATA_END;
			end else if (sel >= 60) begin
				h.opcode = OP_DATA_ACK;
			end
			return h;
		end

		// noise: foreign round, out of range, old number, unowed retransmission
		h.opcode = 2'($urandom_range(0, 2));
		h.packet_number = 8'($urandom_range(PKT_LIMIT, 255));
		if (sel < 86) begin
			h.round_number = cur_round + 16'($urandom_range(1, 65535));
			h.packet_number = 8'($urandom_range(0, 255));
		end else if (sel >= 90 && sel < 94 && next_pkt != 0) begin
			h.packet_number = 8'($urandom_range(0, int'(next_pkt) - 1));
		end else if (sel >= 94) begin
			h.opcode = OP_RETRANS;
			h.round_number = 16'($urandom);
			h.packet_number = 8'($urandom_range(0, 255));
		end
		return h;
	endfunction

	function automatic hdr_item_t make_hdr(logic [1:0] op, logic [15:0] rnd, logic [7:0] pn,
		logic [15:0] dend);
		hdr_item_t h;
		h.opcode = op;
		h.round_number = rnd;
		h.packet_number = pn;
		h.data_end = dend;
		return h;
	endfunction

	task automatic add_row(input hdr_item_t h, input bit typed, input res_item_t want);
		dir_row_t row;
		row.hdr = h;
		row.typed = typed;
		row.want = want;
		directed_rows.push_back(row);
	endtask

	// offer one header transaction and record what it should produce
	task automatic send_header(input hdr_item_t h, input bit typed, input res_item_t want);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			hdr_valid <= 1'b0;
			@(negedge clk);
		end
		hdr <= h;
		hdr_valid <= 1'b1;
		do @(posedge clk); while (hdr_stall);
		predict_header(h);
		if (typed) begin
			expected_results.push_back(want);
		end else begin
			foreach (step_results[i]) expected_results.push_back(step_results[i]);
		end
		@(negedge clk);
	endtask

	// result side stalls, with one long hold on request
	initial begin
		res_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				res_stall <= 1'b1;
				repeat (LONG_HOLD) @(negedge clk);
			end
			res_stall <= ($urandom_range(0, 99) < rx_idle_pct);
		end
	end

	// compare each result transaction with the oldest expectation
	always @(posedge clk) begin : result_check
		res_item_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (expected_results.size() == 0) begin
				flag_error($sformatf("result with nothing expected: %s", res_text(res)));
			end else begin
				want = expected_results.pop_front();
				if (!res_matches(want, res)) begin
					flag_error($sformatf("result mismatch: expected %s, got %s",
						res_text(want), res_text(res)));
				end
			end
		end
	end

	// watchdog on cycles with no transaction on either side
	always @(posedge clk) begin
		if ((hdr_valid && !hdr_stall) || (res_valid && !res_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("tb: errors");
				$finish;
			end
		end
	end

	// reset, directed table, random headers, drain
	initial begin
		arst_n = 1'b0;
		hdr_valid = 1'b0;
		hdr = '0;
		cur_round = '0;
		next_pkt = '0;
		gap_count = '0;
		owed_retrans = '0;
		closing = 1'b0;
		fill_latched = '0;
		foreach (gap_list[i]) gap_list[i] = '0;

		// directed table: round 0 edge cases, then rounds 1 and 2
		add_row(make_hdr(OP_RETRANS, 16'd0, 8'd0, 16'd0), 1'b1,
			single_result(ACT_ERROR, 5'd0, 16'd0, 16'd0));
		add_row(make_hdr(OP_DATA, 16'hFFFF, 8'd0, 16'd32768), 1'b1,
			single_result(ACT_DROP, 5'd0, 16'd0, 16'd0));
		add_row(make_hdr(OP_DATA, 16'd0, 8'd255, 16'd0), 1'b1,
			single_result(ACT_DROP, 5'd0, 16'd0, 16'd0));
		add_row(make_hdr(OP_DATA, 16'd0, 8'(PKT_LIMIT), 16'd0), 1'b1,
			single_result(ACT_DROP, 5'd0, 16'd0, 16'd0));
		add_row(make_hdr(OP_DATA, 16'd0, 8'd0, 16'd32768), 1'b1,
			single_result(ACT_STORE, 5'd0, 16'd0, 16'd32768));
		add_row(make_hdr(OP_DATA, 16'd0, 8'd0, 16'd5), 1'b1,
			single_result(ACT_DROP, 5'd0, 16'd0, 16'd32768));
		add_row(make_hdr(OP_DATA_ACK, 16'd0, 8'd3, 16'd100), 1'b0, '0);
		add_row(make_hdr(OP_DATA, 16'd0, 8'd5, 16'd7), 1'b1,
			single_result(ACT_ERROR, 5'd0, 16'd0, 16'd100));
		add_row(make_hdr(OP_RETRANS, 16'd0, 8'd1, 16'd0), 1'b1,
			single_result(ACT_STORE, 5'd1, 16'd0, 16'd100));
		add_row(make_hdr(OP_RETRANS, 16'h8000, 8'd2, 16'd0), 1'b1,
			single_result(ACT_DROP, 5'd0, 16'd0, 16'd100));
		add_row(make_hdr(OP_RETRANS, 16'd0, 8'd2, 16'd0), 1'b1,
			single_result(ACT_ERROR, 5'd0, 16'd0, 16'd100));
		add_row(make_hdr(OP_DATA_ACK, 16'd0, 8'd4, 16'd200), 1'b0, '0);
		add_row(make_hdr(OP_DATA_END, 16'd0, 8'd7, 16'd300), 1'b0, '0);
		add_row(make_hdr(OP_RETRANS, 16'd0, 8'd200, 16'd0), 1'b1,
			single_result(ACT_DROP, 5'd0, 16'd0, 16'd300));
		add_row(make_hdr(OP_RETRANS, 16'd0, 8'd6, 16'd0), 1'b0, '0);
		add_row(make_hdr(OP_DATA, 16'd0, 8'd8, 16'd0), 1'b1,
			single_result(ACT_DROP, 5'd0, 16'd1, 16'd300));
		add_row(make_hdr(OP_DATA_END, 16'd1, 8'd0, 16'd1), 1'b0, '0);
		add_row(make_hdr(OP_DATA, 16'd2, 8'd30, 16'd16384), 1'b0, '0);
		add_row(make_hdr(OP_DATA_END, 16'd2, 8'd31, 16'd32767), 1'b0, '0);

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[i]) begin
			send_header(directed_rows[i].hdr, directed_rows[i].typed, directed_rows[i].want);
		end

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			// swap idle rates and hold the result side for a long stretch
			if (i == RANDOM_ITEMS / 3) begin
				tx_idle_pct = 46;
				rx_idle_pct = 12;
				long_hold_req = 1'b1;
			end
			// no idling; first let every pending result drain
			if (i == 2 * RANDOM_ITEMS / 3) begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
				hdr_valid <= 1'b0;
				@(negedge clk);
				while (expected_results.size() != 0) @(negedge clk);
			end
			send_header(pick_header(), 1'b0, '0);
		end
		hdr_valid <= 1'b0;

		while (expected_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0) begin
			$display("tb: clean");
		end else begin
			$display("tb: errors");
		end
		$finish;
	end

endmodule
